### rtl/core/cfa_unwind_rule_interpreter_core_assert.svh
// Assertion macros for the interpreter RTL.
`ifndef CFA_UNWIND_RULE_INTERPRETER_CORE_ASSERT_SVH
`define CFA_UNWIND_RULE_INTERPRETER_CORE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define CFAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CFAU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/cfau_pkg.sv
package cfau_pkg;

  // field widths
  localparam int REG_W   = 6;
  localparam int OPND_W  = 32;
  localparam int LOC_W   = 64;
  localparam int OFF_W   = 48;
  localparam int CODE_W  = 16;
  localparam int DATA_W  = 16;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // default table size
  localparam int NUM_REGS_DEF = 64;

  // decoded request queue depth
  localparam int Q_DEPTH = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_BEGIN     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NOP       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_OFFSET    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEF_CFA   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CFA_OFF   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CFA_REG   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNHANDLED = 3'd7;

  // status codes
  localparam logic [STAT_W-1:0] ST_APPLIED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_STOPPED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNHANDLED = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOCFA     = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PC   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_ALIGN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_ALIGN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RET_COLUMN  = 3'd4;

  // configuration reset values
  localparam logic [LOC_W-1:0]         TARGET_PC_RST   = '0;
  localparam logic [LOC_W-1:0]         RANGE_START_RST = '0;
  localparam logic [CODE_W-1:0]        CODE_ALIGN_RST  = 16'd1;
  localparam logic signed [DATA_W-1:0] DATA_ALIGN_RST  = -16'sd8;
  localparam logic [REG_W-1:0]         RET_COLUMN_RST  = 6'd16;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [REG_W-1:0]  reg_num;
    logic [OPND_W-1:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [LOC_W-1:0]        location;
    logic                    cfa_defined;
    logic [REG_W-1:0]        cfa_base_reg;
    logic [OPND_W-1:0]       cfa_off;
    logic                    rule_present;
    logic signed [OFF_W-1:0] rule_off;
    logic                    rule_is_return;
  } out_item_t;

  // decoded request handed from front to back
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [REG_W-1:0]  reg_num;
    logic [OPND_W-1:0] operand;
    logic [OFF_W-1:0]  adv_delta;   // operand * code_align
    logic [OFF_W-1:0]  scaled_off;  // operand * data_align, 48-bit two's complement
    logic              in_table;
    logic              is_return;
  } dec_req_t;

  // queue occupancy flags
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

### rtl/core/cfau_front.sv
module cfau_front import cfau_pkg::*; #(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  input  logic [CODE_W-1:0]        code_align,
  input  logic signed [DATA_W-1:0] data_align,
  input  logic [REG_W-1:0]         return_column,
  input  q_stat_t                  q_stat,
  output logic                     push,
  output dec_req_t                 push_req
);

  localparam logic [REG_W:0] NumRegsV = (REG_W+1)'(NUM_REGS);

  logic signed [OFF_W:0] scaled_prod;
  logic [OFF_W-1:0]      delta_prod;

  // scale operands by the alignment factors
  assign scaled_prod = (OFF_W+1)'($signed({1'b0, in_data.operand})) *
                       (OFF_W+1)'(data_align);
  assign delta_prod  = OFF_W'(in_data.operand) * OFF_W'(code_align);

  // accept whenever the queue has room and reset is low
  assign in_ready = !q_stat.full && !rst;
  assign push     = in_valid && in_ready;

  // classify the request
  always_comb begin
    push_req.cmd        = in_data.cmd;
    push_req.reg_num    = in_data.reg_num;
    push_req.operand    = in_data.operand;
    push_req.adv_delta  = delta_prod;
    push_req.scaled_off = scaled_prod[OFF_W-1:0];
    push_req.in_table   = {1'b0, in_data.reg_num} < NumRegsV;
    push_req.is_return  = in_data.reg_num == return_column;
  end

endmodule

### rtl/core/cfau_queue.sv
module cfau_queue import cfau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  dec_req_t push_req,
  input  logic     pop,
  output dec_req_t head,
  output q_stat_t  q_stat
);

  localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CntW = $clog2(Q_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Q_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Q_DEPTH);

  dec_req_t        slots [Q_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign head         = slots[rd_ptr];
  assign q_stat.empty = count == '0;
  assign q_stat.full  = count == FullCnt;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/cfau_back.sv
module cfau_back import cfau_pkg::*; #(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  dec_req_t         head,
  input  q_stat_t          q_stat,
  output logic             pop,
  input  logic [LOC_W-1:0] target_pc,
  input  logic [LOC_W-1:0] range_start,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int IdxW = $clog2(NUM_REGS);

  // interpreter state
  logic [LOC_W-1:0]    loc;
  logic                halted;
  logic                cfa_vld;
  logic [REG_W-1:0]    cfa_reg;
  logic [OPND_W-1:0]   cfa_offset;
  logic [NUM_REGS-1:0] rule_vld;
  logic [OFF_W-1:0]    rule_mem [NUM_REGS];

  // next state
  logic [LOC_W-1:0]  loc_next;
  logic [LOC_W-1:0]  adv_loc;
  logic              halted_next;
  logic              cfa_vld_next;
  logic [REG_W-1:0]  cfa_reg_next;
  logic [OPND_W-1:0] cfa_offset_next;
  logic [STAT_W-1:0] status_next;
  logic              wr_rule;
  logic              clr_all;
  logic              present_next;
  logic [IdxW-1:0]   idx;

  // result register
  out_item_t        res;
  logic             res_sel_new;
  logic [OFF_W-1:0] res_new_off;
  logic [OFF_W-1:0] rd_off;

  assign idx = head.reg_num[IdxW-1:0];
  assign pop = !q_stat.empty && (!out_valid || out_ready);

  // execute one request
  always_comb begin
    loc_next        = loc;
    halted_next     = halted;
    cfa_vld_next    = cfa_vld;
    cfa_reg_next    = cfa_reg;
    cfa_offset_next = cfa_offset;
    status_next     = ST_APPLIED;
    wr_rule         = 1'b0;
    clr_all         = 1'b0;
    adv_loc         = loc + {{(LOC_W-OFF_W){1'b0}}, head.adv_delta};
    if (head.cmd == CMD_BEGIN) begin
      loc_next        = range_start;
      halted_next     = 1'b0;
      cfa_vld_next    = 1'b0;
      cfa_reg_next    = '0;
      cfa_offset_next = '0;
      clr_all         = 1'b1;
    end else if (halted) begin
      status_next = ST_IGNORED;
    end else begin
      unique case (head.cmd)
        CMD_BEGIN, CMD_NOP: begin
        end
        CMD_ADVANCE: begin
          if (target_pc >= adv_loc) begin
            loc_next = adv_loc;
          end else begin
            halted_next = 1'b1;
            status_next = ST_STOPPED;
          end
        end
        CMD_OFFSET: begin
          wr_rule = head.in_table;
        end
        CMD_DEF_CFA: begin
          cfa_vld_next    = 1'b1;
          cfa_reg_next    = head.reg_num;
          cfa_offset_next = head.operand;
        end
        CMD_CFA_OFF: begin
          if (cfa_vld) begin
            cfa_offset_next = head.operand;
          end else begin
            halted_next = 1'b1;
            status_next = ST_NOCFA;
          end
        end
        CMD_CFA_REG: begin
          if (cfa_vld) begin
            cfa_reg_next = head.reg_num;
          end else begin
            halted_next = 1'b1;
            status_next = ST_NOCFA;
          end
        end
        CMD_UNHANDLED: begin
          halted_next = 1'b1;
          status_next = ST_UNHANDLED;
        end
      endcase
    end
    // rule of the named register after this step
    if (clr_all) begin
      present_next = 1'b0;
    end else if (wr_rule) begin
      present_next = 1'b1;
    end else begin
      present_next = head.in_table && rule_vld[idx];
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      loc        <= '0;
      halted     <= 1'b0;
      cfa_vld    <= 1'b0;
      cfa_reg    <= '0;
      cfa_offset <= '0;
      rule_vld   <= '0;
    end else if (pop) begin
      loc        <= loc_next;
      halted     <= halted_next;
      cfa_vld    <= cfa_vld_next;
      cfa_reg    <= cfa_reg_next;
      cfa_offset <= cfa_offset_next;
      if (clr_all) begin
        rule_vld <= '0;
      end else if (wr_rule) begin
        rule_vld[idx] <= 1'b1;
      end
    end
  end

  // rule offset table: read old value, bypass a same-step write
  always_ff @(posedge clk) begin
    if (pop && wr_rule) begin
      rule_mem[idx] <= head.scaled_off;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_off <= rule_mem[idx];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.status         <= status_next;
      res.location       <= loc_next;
      res.cfa_defined    <= cfa_vld_next;
      res.cfa_base_reg   <= cfa_vld_next ? cfa_reg_next : '0;
      res.cfa_off        <= cfa_vld_next ? cfa_offset_next : '0;
      res.rule_present   <= present_next;
      res.rule_off       <= '0;
      res.rule_is_return <= head.is_return;
      res_sel_new        <= wr_rule;
      res_new_off        <= head.scaled_off;
    end
  end

  always_comb begin
    out_data = res;
    if (!res.rule_present) begin
      out_data.rule_off = '0;
    end else if (res_sel_new) begin
      out_data.rule_off = $signed(res_new_off);
    end else begin
      out_data.rule_off = $signed(rd_off);
    end
  end

endmodule

### rtl/core/cfa_unwind_rule_interpreter_core.sv
// Call frame rule interpreter: takes one pre-decoded call frame request per
// cycle and returns one result per request, in order. An accepted request
// is decoded into a two-entry queue and then executed from the queue into
// the output register. Sustained rate is one request per cycle while the
// result is taken, with the execute step doing a 64-bit location add and
// compare against target_pc. A held result stalls the execute step; the
// input stalls once both queue entries are taken. The rule table needs no
// clearing pass after reset: per-register valid bits gate the offset
// storage. Write configuration only while no request is in flight.
`include "cfa_unwind_rule_interpreter_core_assert.svh"

module cfa_unwind_rule_interpreter_core import cfau_pkg::*; #(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [LOC_W-1:0]         target_pc;
  logic [LOC_W-1:0]         range_start;
  logic [CODE_W-1:0]        code_align;
  logic signed [DATA_W-1:0] data_align;
  logic [REG_W-1:0]         return_column;

  logic     push;
  logic     pop;
  dec_req_t push_req;
  dec_req_t head;
  q_stat_t  q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_pc     <= TARGET_PC_RST;
      range_start   <= RANGE_START_RST;
      code_align    <= CODE_ALIGN_RST;
      data_align    <= DATA_ALIGN_RST;
      return_column <= RET_COLUMN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TARGET_PC:   target_pc     <= cfg_data;
        CFG_RANGE_START: range_start   <= cfg_data;
        CFG_CODE_ALIGN:  code_align    <= cfg_data[CODE_W-1:0];
        CFG_DATA_ALIGN:  data_align    <= $signed(cfg_data[DATA_W-1:0]);
        CFG_RET_COLUMN:  return_column <= cfg_data[REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: accept and decode
  cfau_front #(
    .NUM_REGS(NUM_REGS)
  ) u_front (
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .code_align   (code_align),
    .data_align   (data_align),
    .return_column(return_column),
    .q_stat       (q_stat),
    .push         (push),
    .push_req     (push_req)
  );

  // decoded request queue
  cfau_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_req(push_req),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  // back: execute and hold the result
  cfau_back #(
    .NUM_REGS(NUM_REGS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .target_pc  (target_pc),
    .range_start(range_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // checks
  `CFAU_ASSERT_ALWAYS(a_rst_idle, rst |=> !out_valid, "result valid right after reset")
  `CFAU_ASSERT(a_push_fills, push |=> !q_stat.empty, "accepted request missing from queue")
  `CFAU_ASSERT(a_nocfa_undef, (out_valid && out_data.status == ST_NOCFA) |-> !out_data.cfa_defined, "no-CFA status with a CFA rule")
  `CFAU_ASSERT(a_rule_gated, (out_valid && !out_data.rule_present) |-> (out_data.rule_off == '0), "rule offset without rule")

endmodule

### bench/cfa_unwind_rule_interpreter_core_tb.sv
`timescale 1ns / 1ps

module cfa_unwind_rule_interpreter_core_tb;
  import cfau_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 12;
  localparam int PHASE_WORK  = 140;

  // one directed row: request, and optionally the result typed in by hand
  typedef struct packed {
    in_item_t  req;
    logic      pin;
    out_item_t row;
  } dir_row_t;

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // fresh out of reset, query the return column
    '{'{CMD_NOP, 6'd16, 32'd0}, 1'b1,
      '{ST_APPLIED, 64'd0, 1'b0, 6'd0, 32'd0, 1'b0, 48'sd0, 1'b1}},
    '{'{CMD_UNHANDLED, 6'd0, 32'd0}, 1'b1,
      '{ST_UNHANDLED, 64'd0, 1'b0, 6'd0, 32'd0, 1'b0, 48'sd0, 1'b0}},
    '{'{CMD_NOP, 6'd1, 32'd0}, 1'b1,
      '{ST_IGNORED, 64'd0, 1'b0, 6'd0, 32'd0, 1'b0, 48'sd0, 1'b0}},
    '{'{CMD_BEGIN, 6'd0, 32'd0}, 1'b1,
      '{ST_APPLIED, 64'd0, 1'b0, 6'd0, 32'd0, 1'b0, 48'sd0, 1'b0}},
    // register change with no CFA rule
    '{'{CMD_CFA_REG, 6'd7, 32'd0}, 1'b1,
      '{ST_NOCFA, 64'd0, 1'b0, 6'd0, 32'd0, 1'b0, 48'sd0, 1'b0}},
    '{'{CMD_BEGIN, 6'd16, 32'hFFFF_FFFF}, 1'b1,
      '{ST_APPLIED, 64'd0, 1'b0, 6'd0, 32'd0, 1'b0, 48'sd0, 1'b1}},
    // offset change with no CFA rule
    '{'{CMD_CFA_OFF, 6'd0, 32'd1}, 1'b1,
      '{ST_NOCFA, 64'd0, 1'b0, 6'd0, 32'd0, 1'b0, 48'sd0, 1'b0}},
    '{'{CMD_BEGIN, 6'd63, 32'hFFFF_FFFF}, 1'b1,
      '{ST_APPLIED, 64'd0, 1'b0, 6'd0, 32'd0, 1'b0, 48'sd0, 1'b0}},
    '{'{CMD_DEF_CFA, 6'd63, 32'hFFFF_FFFF}, 1'b1,
      '{ST_APPLIED, 64'd0, 1'b1, 6'd63, 32'hFFFF_FFFF, 1'b0, 48'sd0, 1'b0}},
    '{'{CMD_OFFSET, 6'd63, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{CMD_OFFSET, 6'd16, 32'd0}, 1'b0, '0},
    '{'{CMD_OFFSET, 6'd0, 32'd1}, 1'b1,
      '{ST_APPLIED, 64'd0, 1'b1, 6'd63, 32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFF8, 1'b0}},
    '{'{CMD_CFA_OFF, 6'd2, 32'd0}, 1'b0, '0},
    '{'{CMD_CFA_REG, 6'd0, 32'd0}, 1'b0, '0},
    '{'{CMD_NOP, 6'd63, 32'd0}, 1'b0, '0},
    '{'{CMD_ADVANCE, 6'd0, 32'd0}, 1'b0, '0},
    '{'{CMD_ADVANCE, 6'd0, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{CMD_OFFSET, 6'd5, 32'd7}, 1'b0, '0},
    '{'{CMD_CFA_OFF, 6'd0, 32'd9}, 1'b0, '0},
    // begin clears a stopped interpreter and every saved rule
    '{'{CMD_BEGIN, 6'd63, 32'd0}, 1'b1,
      '{ST_APPLIED, 64'd0, 1'b0, 6'd0, 32'd0, 1'b0, 48'sd0, 1'b0}},
    '{'{CMD_DEF_CFA, 6'd0, 32'd0}, 1'b0, '0},
    '{'{CMD_ADVANCE, 6'd0, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{CMD_DEF_CFA, 6'd1, 32'd5}, 1'b0, '0},
    '{'{CMD_BEGIN, 6'd16, 32'd0}, 1'b1,
      '{ST_APPLIED, 64'd0, 1'b0, 6'd0, 32'd0, 1'b0, 48'sd0, 1'b1}}
  };

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // interpreter mirror: configuration
  logic [LOC_W-1:0]         tgt_pc;
  logic [LOC_W-1:0]         rng_start;
  logic [CODE_W-1:0]        code_al;
  logic signed [DATA_W-1:0] data_al;
  logic [REG_W-1:0]         ret_col;

  // interpreter mirror: state
  logic [LOC_W-1:0]        loc_ctr;
  logic                    stopped;
  logic                    cfa_set;
  logic [REG_W-1:0]        cfa_base;
  logic [OPND_W-1:0]       cfa_ofs;
  logic [NUM_REGS_DEF-1:0] saved_ok;
  logic [OFF_W-1:0]        saved_ofs [NUM_REGS_DEF];

  out_item_t frame_rows_q [$];
  logic      pin_on  = 1'b0;
  out_item_t pin_row = '0;
  int        req_cnt      = 0;
  int        mismatch_cnt = 0;
  int        cycle_cnt    = 0;
  int        stall_left   = 0;
  logic      quiet        = 1'b0;

  cfa_unwind_rule_interpreter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one; none while quiet
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [OPND_W-1:0] rand_opnd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '1;
    if (r < 70) return OPND_W'($urandom_range(0, 15));
    if (r < 85) return OPND_W'($urandom_range(16, 65535));
    return $urandom;
  endfunction

  // small pool of registers so saved rules get queried back
  function automatic logic [REG_W-1:0] pick_reg();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return ret_col;
    if (r == 3) return REG_W'($urandom);
    return REG_W'($urandom_range(0, 7));
  endfunction

  function automatic in_item_t cfi(logic [CMD_W-1:0] c, logic [REG_W-1:0] rn,
                                   logic [OPND_W-1:0] op);
    in_item_t r;
    r.cmd     = c;
    r.reg_num = rn;
    r.operand = op;
    return r;
  endfunction

  // one call frame instruction against the mirrored state
  function automatic out_item_t interpret_cfi(in_item_t r);
    out_item_t          o;
    logic [LOC_W-1:0]   nxt;
    logic               in_tab;
    longint             prod;
    o        = '0;
    o.status = ST_APPLIED;
    in_tab   = int'(r.reg_num) < NUM_REGS_DEF;
    if (r.cmd == CMD_BEGIN) begin
      loc_ctr  = rng_start;
      stopped  = 1'b0;
      cfa_set  = 1'b0;
      cfa_base = '0;
      cfa_ofs  = '0;
      saved_ok = '0;
    end else if (stopped) begin
      o.status = ST_IGNORED;
    end else begin
      case (r.cmd)
        CMD_NOP: ;
        CMD_ADVANCE: begin
          nxt = loc_ctr + LOC_W'(r.operand) * LOC_W'(code_al);
          if (tgt_pc >= nxt) begin
            loc_ctr = nxt;
          end else begin
            stopped  = 1'b1;
            o.status = ST_STOPPED;
          end
        end
        CMD_OFFSET: begin
          if (in_tab) begin
            prod                 = longint'(r.operand) * longint'(data_al);
            saved_ok[r.reg_num]  = 1'b1;
            saved_ofs[r.reg_num] = prod[OFF_W-1:0];
          end
        end
        CMD_DEF_CFA: begin
          cfa_set  = 1'b1;
          cfa_base = r.reg_num;
          cfa_ofs  = r.operand;
        end
        CMD_CFA_OFF, CMD_CFA_REG: begin
          if (!cfa_set) begin
            stopped  = 1'b1;
            o.status = ST_NOCFA;
          end else if (r.cmd == CMD_CFA_OFF) begin
            cfa_ofs = r.operand;
          end else begin
            cfa_base = r.reg_num;
          end
        end
        default: begin
          stopped  = 1'b1;
          o.status = ST_UNHANDLED;
        end
      endcase
    end
    o.location    = loc_ctr;
    o.cfa_defined = cfa_set;
    if (cfa_set) begin
      o.cfa_base_reg = cfa_base;
      o.cfa_off      = cfa_ofs;
    end
    if (in_tab && saved_ok[r.reg_num]) begin
      o.rule_present = 1'b1;
      o.rule_off     = saved_ofs[r.reg_num];
    end
    o.rule_is_return = (r.reg_num == ret_col);
    return o;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 50) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_row(out_item_t got, out_item_t want);
    if (got.status !== want.status)
      flag_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.location !== want.location)
      flag_mismatch($sformatf("location got %h want %h", got.location, want.location));
    if (got.cfa_defined !== want.cfa_defined)
      flag_mismatch($sformatf("cfa_defined got %b want %b", got.cfa_defined,
                              want.cfa_defined));
    if (got.cfa_base_reg !== want.cfa_base_reg)
      flag_mismatch($sformatf("cfa_base_reg got %0d want %0d", got.cfa_base_reg,
                              want.cfa_base_reg));
    if (got.cfa_off !== want.cfa_off)
      flag_mismatch($sformatf("cfa_off got %h want %h", got.cfa_off, want.cfa_off));
    if (got.rule_present !== want.rule_present)
      flag_mismatch($sformatf("rule_present got %b want %b", got.rule_present,
                              want.rule_present));
    if (got.rule_off !== want.rule_off)
      flag_mismatch($sformatf("rule_off got %0d want %0d", got.rule_off, want.rule_off));
    if (got.rule_is_return !== want.rule_is_return)
      flag_mismatch($sformatf("rule_is_return got %b want %b", got.rule_is_return,
                              want.rule_is_return));
  endtask

  // mirror config writes, predict on request accept, check on result accept
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      tgt_pc    = TARGET_PC_RST;
      rng_start = RANGE_START_RST;
      code_al   = CODE_ALIGN_RST;
      data_al   = DATA_ALIGN_RST;
      ret_col   = RET_COLUMN_RST;
      loc_ctr   = '0;
      stopped   = 1'b0;
      cfa_set   = 1'b0;
      cfa_base  = '0;
      cfa_ofs   = '0;
      saved_ok  = '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_TARGET_PC:   tgt_pc    = cfg_data;
          CFG_RANGE_START: rng_start = cfg_data;
          CFG_CODE_ALIGN:  code_al   = cfg_data[CODE_W-1:0];
          CFG_DATA_ALIGN:  data_al   = cfg_data[DATA_W-1:0];
          CFG_RET_COLUMN:  ret_col   = cfg_data[REG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = interpret_cfi(in_data);
        req_cnt++;
        if (pin_on) want = pin_row;
        frame_rows_q.insert(frame_rows_q.size(), want);
      end
      if (out_valid && out_ready) begin
        if (frame_rows_q.size() == 0) begin
          flag_mismatch("result with no request pending");
        end else begin
          want = frame_rows_q.pop_front();
          check_row(out_data, want);
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after accept,
  // leaving valid high so back-to-back requests need no second assignment
  task automatic send_req(in_item_t r, logic pin = 1'b0, out_item_t row = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pin_on   = pin;
    pin_row  = row;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // drop valid and wait for every pending result
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (frame_rows_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_config(logic [LOC_W-1:0] tpc, logic [LOC_W-1:0] rs,
                            logic [CODE_W-1:0] ca, logic [DATA_W-1:0] da,
                            logic [REG_W-1:0] rc);
    cfg_write <= 1'b1;
    cfg_index <= CFG_TARGET_PC;
    cfg_data  <= tpc;
    @(negedge clk);
    cfg_index <= CFG_RANGE_START;
    cfg_data  <= rs;
    @(negedge clk);
    cfg_index <= CFG_CODE_ALIGN;
    cfg_data  <= CFG_DATA_W'(ca);
    @(negedge clk);
    cfg_index <= CFG_DATA_ALIGN;
    cfg_data  <= CFG_DATA_W'(da);
    @(negedge clk);
    cfg_index <= CFG_RET_COLUMN;
    cfg_data  <= CFG_DATA_W'(rc);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // frame program: begin, usually define the CFA, then a random mix of requests
  task automatic run_frame_program();
    int n;
    int k;
    int pick;
    n = $urandom_range(4, 24);
    send_req(cfi(CMD_BEGIN, REG_W'($urandom), $urandom));
    if ($urandom_range(0, 9) != 0) send_req(cfi(CMD_DEF_CFA, pick_reg(), rand_opnd()));
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      send_req(cfi(CMD_ADVANCE, pick_reg(), rand_opnd()));
      else if (pick < 55) send_req(cfi(CMD_OFFSET, pick_reg(), rand_opnd()));
      else if (pick < 64) send_req(cfi(CMD_CFA_OFF, pick_reg(), rand_opnd()));
      else if (pick < 72) send_req(cfi(CMD_CFA_REG, pick_reg(), rand_opnd()));
      else if (pick < 78) send_req(cfi(CMD_DEF_CFA, pick_reg(), rand_opnd()));
      else if (pick < 97) send_req(cfi(CMD_NOP, pick_reg(), rand_opnd()));
      else                send_req(cfi(CMD_UNHANDLED, pick_reg(), rand_opnd()));
    end
  endtask

  initial begin
    int               i;
    int               ph;
    int               goal;
    logic [LOC_W-1:0] tpc;
    logic [LOC_W-1:0] rs;
    logic [CODE_W-1:0] ca;
    logic [DATA_W-1:0] da;
    logic [REG_W-1:0] rc;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows under the reset configuration
    for (i = 0; i < DIR_ROWS; i++) send_req(DIR_TAB[i].req, DIR_TAB[i].pin, DIR_TAB[i].row);
    drain_results();

    // random phases, each under its own configuration
    for (ph = 0; ph < PHASES; ph++) begin
      quiet = (ph % 4 == 3);
      case (ph % 6)
        0: begin
          rs  = {$urandom, $urandom};
          tpc = rs + LOC_W'($urandom_range(0, 4096));
          ca  = CODE_W'($urandom_range(1, 8));
          da  = DATA_W'($urandom);
          rc  = REG_W'($urandom);
        end
        1: begin
          // every advance taken, largest factors
          rs  = {$urandom, $urandom};
          tpc = '1;
          ca  = '1;
          da  = 16'h7FFF;
          rc  = 6'd63;
        end
        2: begin
          // zero code alignment, most negative data alignment
          rs  = '0;
          tpc = '0;
          ca  = '0;
          da  = 16'h8000;
          rc  = '0;
        end
        3: begin
          // advances that wrap past the top of the address space
          rs  = 64'hFFFF_FFFF_FFFF_F000;
          tpc = 64'h0000_0001_0000_0000;
          ca  = CODE_W'($urandom_range(1, 4));
          da  = 16'hFFFF;
          rc  = REG_W'($urandom);
        end
        4: begin
          rs  = LOC_W'($urandom) << 4;
          tpc = rs + 64'd300;
          ca  = CODE_ALIGN_RST;
          da  = DATA_ALIGN_RST;
          rc  = RET_COLUMN_RST;
        end
        default: begin
          rs  = {$urandom, $urandom};
          tpc = {$urandom, $urandom};
          ca  = CODE_W'($urandom);
          da  = DATA_W'($urandom);
          rc  = REG_W'($urandom);
        end
      endcase
      set_config(tpc, rs, ca, da, rc);

      goal = req_cnt + PHASE_WORK;
      while (req_cnt < goal) begin
        if ($urandom_range(0, 9) < 8) begin
          run_frame_program();
        end else begin
          repeat ($urandom_range(1, 5))
            send_req(cfi(CMD_W'($urandom), REG_W'($urandom), $urandom));
        end
      end
      drain_results();
    end

    repeat (10) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/cfau_pkg.sv
rtl/core/cfau_front.sv
rtl/core/cfau_queue.sv
rtl/core/cfau_back.sv
rtl/core/cfa_unwind_rule_interpreter_core.sv
bench/cfa_unwind_rule_interpreter_core_tb.sv
